// File: src/dtl_pkg.sv
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types and constants for the debounced toggle light with beep timer.
// ----------------------------------------------------------------------------
package dtl_pkg;

  localparam int unsigned DebW      = 16;
  localparam int unsigned BuzzW     = 16;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned DriveW    = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  localparam logic [DebW-1:0]      DebounceRst = DebW'(50);
  localparam logic [BuzzW-1:0]     BuzzRst     = BuzzW'(250);
  localparam logic [IntervalW-1:0] IntervalRst = IntervalW'(180 * 1000);
  localparam logic [DriveW-1:0]    DriveRst    = DriveW'(150);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 8'd0,
    REG_BUZZ     = 8'd1,
    REG_INTERVAL = 8'd2,
    REG_DRIVE    = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DebW-1:0]      debounce_ticks;
    logic [BuzzW-1:0]     buzz_ticks;
    logic [IntervalW-1:0] beep_interval_ticks;
    logic [DriveW-1:0]    buzzer_drive;
  } cfg_t;

  typedef struct packed {
    logic              stable_switch;
    logic [DriveW-1:0] buzzer_level;
    logic              light_on;
  } result_t;

endpackage

// File: src/debounced_toggle_light_with_beep_timer_top.sv
// ----------------------------------------------------------------------------
// debounced_toggle_light_with_beep_timer_top
// Debounced push-button light toggle with repeating beep, one tick per item.
// ----------------------------------------------------------------------------
// The result of an accepted tick is computed combinationally and captured in the output register.
// Throughput: one tick per cycle while the output is not stalled; the tick state updates on each accepted tick.
// The input is ready whenever the output register is empty or being drained.
// Reset (async, active low) clears all tick state, empties the output
// register and loads the configuration registers with their defaults.
module debounced_toggle_light_with_beep_timer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] switch_level, rest zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dtl_pkg::InDataW-1:0]   s_axis_tdata,
  // tdata: [0] light_on, [8:1] buzzer_level, [9] stable_switch, rest zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dtl_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dtl_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dtl_pkg::*;

  cfg_t    cfg_q;
  result_t result;
  result_t res_q;
  logic    out_valid_q;
  logic    step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= DebounceRst;
      cfg_q.buzz_ticks          <= BuzzRst;
      cfg_q.beep_interval_ticks <= IntervalRst;
      cfg_q.buzzer_drive        <= DriveRst;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_DEBOUNCE: cfg_q.debounce_ticks      <= cfg_data_i[DebW-1:0];
        REG_BUZZ:     cfg_q.buzz_ticks          <= cfg_data_i[BuzzW-1:0];
        REG_INTERVAL: cfg_q.beep_interval_ticks <= cfg_data_i[IntervalW-1:0];
        REG_DRIVE:    cfg_q.buzzer_drive        <= cfg_data_i[DriveW-1:0];
        default: ;
      endcase
    end
  end

  dtl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (s_axis_tdata[0]),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

endmodule

// File: src/dtl_core.sv
// ----------------------------------------------------------------------------
// dtl_core
// Tick state: debouncer, light toggle, interval timer and buzzer timer.
// ----------------------------------------------------------------------------
module dtl_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            level_i,
  input  dtl_pkg::cfg_t   cfg_i,
  output dtl_pkg::result_t result_o
);
  import dtl_pkg::*;

  logic                 dl_q, dl_d;
  logic                 dr_q, dr_d;
  logic [DebW-1:0]      de_q, de_d;
  logic                 light_q, light_d;
  logic [IntervalW-1:0] ie_q, ie_d;
  logic                 br_q, br_d;
  logic [BuzzW-1:0]     be_q, be_d;
  logic                 accepted;

  always_comb begin
    // counters advance first, saturating
    be_d = (br_q && (be_q != '1)) ? be_q + BuzzW'(1) : be_q;
    ie_d = (light_q && (ie_q != '1)) ? ie_q + IntervalW'(1) : ie_q;
    de_d = (dr_q && (de_q != '1)) ? de_q + DebW'(1) : de_q;
    dl_d = dl_q;
    dr_d = dr_q;
    light_d = light_q;
    br_d = br_q;
    accepted = 1'b0;

    if (level_i != dl_q) begin
      if (!dr_q) begin
        dr_d = 1'b1;
        de_d = '0;
      end else if (de_d >= cfg_i.debounce_ticks) begin
        dr_d = 1'b0;
        dl_d = level_i;
        accepted = 1'b1;
      end
    end else begin
      dr_d = 1'b0;
    end

    if (accepted && level_i) begin
      light_d = !light_q;
      if (!light_q) begin
        br_d = 1'b1;
        be_d = '0;
        ie_d = '0;
      end
    end

    if (light_d && (ie_d >= cfg_i.beep_interval_ticks)) begin
      ie_d = '0;
      br_d = 1'b1;
      be_d = '0;
    end

    if (br_d && (be_d >= cfg_i.buzz_ticks)) begin
      br_d = 1'b0;
    end

    result_o.light_on      = light_d;
    result_o.buzzer_level  = br_d ? cfg_i.buzzer_drive : '0;
    result_o.stable_switch = dl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q    <= 1'b0;
      dr_q    <= 1'b0;
      de_q    <= '0;
      light_q <= 1'b0;
      ie_q    <= '0;
      br_q    <= 1'b0;
      be_q    <= '0;
    end else if (step_i) begin
      dl_q    <= dl_d;
      dr_q    <= dr_d;
      de_q    <= de_d;
      light_q <= light_d;
      ie_q    <= ie_d;
      br_q    <= br_d;
      be_q    <= be_d;
    end
  end

`ifndef ASSERT_OFF
  a_level_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(dl_q) && $stable(light_q))
    else $error("debounced level or light moved without a tick");

  a_accept_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (dl_d != dl_q) |-> dr_q && !dr_d)
    else $error("level accepted without a running debounce check");

  a_light_on_restarts_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(light_q) |-> (ie_q == '0))
    else $error("interval count not restarted when light turned on");

  a_toggle_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (light_d != light_q) |-> accepted && level_i)
    else $error("light toggled without an accepted press");
`endif

endmodule
